FILE: rtl/mrrp_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the
// response parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrrp_pkg;

    localparam int STORE_REGS = 64;
    localparam int ADDR_W     = $clog2(STORE_REGS);
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int REG_W      = 16;

    localparam logic [CNT_W-1:0]  LIMIT_RESET = 7'd64;
    localparam logic [IDX_W-1:0]  IDX_MAX     = 9'd511;
    localparam logic [REG_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [REG_W-1:0]  CRC_POLY    = 16'hA001;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_ODD_COUNT = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_CRC_BAD   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_SEND
    } t_back_state;

    // Judgement of one frame, passed from front to back
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             bank;
    } t_verdict;

    // Register store write port
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [REG_W-1:0]  data;
    } t_wr_port;

    function automatic logic [REG_W-1:0] crc_byte(input logic [REG_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [REG_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mrrp_front.sv
// Front end: takes frame bytes, keeps the running CRC, writes register
// values into the store and judges the frame on its final byte. Uses mrrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrrp_front
    import mrrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [BYTE_W-1:0]  i_data_byte,
    input  wire logic               i_frame_end,
    input  wire logic [CNT_W-1:0]   i_register_limit,
    output t_wr_port                o_wr,
    output logic                    o_push,
    output t_verdict                o_verdict
);

    logic [IDX_W-1:0]  r_idx,  n_idx;
    logic [7:0]        r_decl, n_decl;
    logic [REG_W-1:0]  r_crc,  n_crc;
    logic [REG_W-1:0]  r_rcrc, n_rcrc;
    logic [7:0]        r_hold, n_hold;
    logic              r_bank, n_bank;

    logic [REG_W-1:0]  crc_next;
    logic [9:0]        data_end;
    logic [IDX_W-1:0]  off;
    logic [CNT_W-1:0]  nregs;
    logic [CNT_W-1:0]  lim;
    t_status           status;

    always_comb begin
        n_idx    = r_idx;
        n_decl   = r_decl;
        n_crc    = r_crc;
        n_rcrc   = r_rcrc;
        n_hold   = r_hold;
        n_bank   = r_bank;
        crc_next = crc_byte(r_crc, i_data_byte);
        data_end = {2'b00, r_decl} + 10'd3;
        off      = r_idx - 9'd3;
        o_wr     = '0;
        o_wr.bank = r_bank;
        o_wr.addr = off[ADDR_W:1];
        o_wr.data = {r_hold, i_data_byte};
        o_push   = 1'b0;
        nregs    = '0;
        lim      = '0;
        status   = ST_OK;
        o_verdict = '0;

        if (i_accept) begin
            if (r_idx < 9'd3) begin
                if (r_idx == 9'd2) begin
                    n_decl = i_data_byte;
                end
                n_crc = crc_next;
            end else if ({1'b0, r_idx} < data_end) begin
                n_crc = crc_next;
                if (!off[0]) begin
                    n_hold = i_data_byte;
                end else if (off[8:1] < 8'(STORE_REGS)) begin
                    o_wr.en = 1'b1;
                end
            end else if ({1'b0, r_idx} == data_end) begin
                n_rcrc[7:0] = i_data_byte;
            end else if ({1'b0, r_idx} == data_end + 10'd1) begin
                n_rcrc[15:8] = i_data_byte;
            end
            // length saturates
            if (r_idx != IDX_MAX) begin
                n_idx = r_idx + 9'd1;
            end

            if (i_frame_end) begin
                nregs = n_decl[7:1];
                lim   = (i_register_limit > CNT_W'(STORE_REGS)) ? CNT_W'(STORE_REGS)
                                                               : i_register_limit;
                if (n_idx < 9'd5) begin
                    status = ST_SHORT;
                end else if (n_decl[0]) begin
                    status = ST_ODD_COUNT;
                end else if (nregs > lim) begin
                    status = ST_TOO_MANY;
                end else if ({1'b0, n_idx} < ({2'b00, n_decl} + 10'd5)) begin
                    status = ST_TRUNCATED;
                end else if (n_crc != n_rcrc) begin
                    status = ST_CRC_BAD;
                end
                o_push           = 1'b1;
                o_verdict.status = status;
                o_verdict.count  = (status == ST_OK) ? nregs : '0;
                o_verdict.bank   = r_bank;
                // hand the filled bank to the back end, start the next frame
                n_bank = ~r_bank;
                n_idx  = '0;
                n_decl = '0;
                n_crc  = CRC_INIT;
                n_rcrc = '0;
                n_hold = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_decl <= '0;
            r_crc  <= CRC_INIT;
            r_rcrc <= '0;
            r_hold <= '0;
            r_bank <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_decl <= n_decl;
            r_crc  <= n_crc;
            r_rcrc <= n_rcrc;
            r_hold <= n_hold;
            r_bank <= n_bank;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mrrp_fifo.sv
// Two-entry queue of frame verdicts between front and back end.
// Uses mrrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrrp_fifo
    import mrrp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_verdict i_data,
    input  wire logic     i_pop,
    output t_verdict      o_head,
    output logic          o_valid,
    output logic          o_full
);

    t_verdict    r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mrrp_back.sv
// Back end: double-banked register store and the result sequencer that
// reads a judged frame out through the output register. Uses mrrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrrp_back
    import mrrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_wr_port           i_wr,
    input  wire t_verdict           i_head,
    input  wire logic               i_head_valid,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [REG_W-1:0]        o_reg_value,
    output logic [2:0]              o_status,
    output logic [CNT_W-1:0]        o_reg_count,
    output logic                    o_last
);

    logic [REG_W-1:0]   r_mem [2*STORE_REGS];
    logic [REG_W-1:0]   r_rd_data;
    logic [ADDR_W:0]    rd_addr;

    t_back_state        r_state, n_state;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [REG_W-1:0]   r_value, n_value;
    logic [2:0]         r_stat, n_stat;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.addr}] <= i_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_value = r_value;
        n_stat  = r_stat;
        n_cnt   = r_cnt;
        n_last  = r_last;
        rd_addr = {i_head.bank, r_idx};
        o_pop   = 1'b0;
        o_valid = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.count == '0) begin
                        // error or empty frame: a single status item
                        n_value = '0;
                        n_stat  = i_head.status;
                        n_cnt   = '0;
                        n_last  = 1'b1;
                        n_state = BK_SEND;
                    end else begin
                        n_idx   = '0;
                        rd_addr = {i_head.bank, {ADDR_W{1'b0}}};
                        n_state = BK_FETCH;
                    end
                end
            end
            BK_FETCH: begin
                n_value = r_rd_data;
                n_stat  = ST_OK;
                n_cnt   = i_head.count;
                n_last  = ({1'b0, r_idx} + 7'd1) == i_head.count;
                n_state = BK_SEND;
            end
            BK_SEND: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (r_last) begin
                        // frame done: release its verdict and bank
                        o_pop   = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_addr = {i_head.bank, n_idx};
                        n_state = BK_FETCH;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_value <= n_value;
        r_stat  <= n_stat;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
    end

    assign o_reg_value = r_value;
    assign o_status    = r_stat;
    assign o_reg_count = r_cnt;
    assign o_last      = r_last;

endmodule

`default_nettype wire

FILE: rtl/modbus_read_response_parser.sv
// Modbus RTU read-holding-registers response parser, top level.
// Depends on mrrp_pkg, mrrp_front, mrrp_fifo and mrrp_back.
//
// Bytes of a function 03 response enter one per cycle on the slave stream,
// tlast on the final byte of the frame. The CRC-16/Modbus is updated per
// byte and the frame is judged on its final byte; input stalls only while
// two judged frames still wait for output, since the register store has
// two banks and the verdict queue two entries. A successful frame gives one
// result per register; each goes through a store read, an output register
// load and the transfer, and the next store read starts with the transfer.
// An error or empty frame gives one status item. The register limit is
// written on the config channel, always ready.
`timescale 1ns / 1ps
`default_nettype none

module modbus_read_response_parser
    import mrrp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic         i_s_axis_tlast,   // frame_end
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // [15:0] reg_value, [18:16] status,
                                                // [25:19] reg_count, [31:26] zero
    output logic              o_m_axis_tlast,   // last
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [6:0]   i_cfg_data        // register_limit
);

    logic [CNT_W-1:0]  r_register_limit;
    logic              in_accept;
    t_wr_port          wr;
    logic              push;
    t_verdict          verdict;
    t_verdict          head;
    logic              head_valid;
    logic              fifo_full;
    logic              pop;
    logic [REG_W-1:0]  reg_value;
    logic [2:0]        status;
    logic [CNT_W-1:0]  reg_count;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = ~fifo_full;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_register_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_register_limit <= i_cfg_data;
        end
    end

    mrrp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_data_byte      (i_s_axis_tdata),
        .i_frame_end      (i_s_axis_tlast),
        .i_register_limit (r_register_limit),
        .o_wr             (wr),
        .o_push           (push),
        .o_verdict        (verdict)
    );

    mrrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (verdict),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (head_valid),
        .o_full  (fifo_full)
    );

    mrrp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_reg_value  (reg_value),
        .o_status     (status),
        .o_reg_count  (reg_count),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'b000000, reg_count, status, reg_value};

`ifndef SYNTHESIS
    // the queue never takes a verdict while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && fifo_full))
        else $error("verdict queue overflow");

    // an error result is a lone item with no count
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (status != ST_OK)) |-> (o_m_axis_tlast && (reg_count == '0)))
        else $error("error result malformed");

    // after a non-final register transfer the store is read again
    a_fetch_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("register result without store read");
`endif

endmodule

`default_nettype wire
